// ===== rtl/core/bitu_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary image thinning package
// Shared transaction types, command and status bundles, controller states and
// the neighbor offset tables of the thinning scan.
// ----------------------------------------------------------------------------
package bitu_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_MAX_ITERATIONS = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [3:0]  STEP_LAST = 4'd9;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] row;
    logic [5:0] col;
    logic       pixel_in;
  } in_item_t;

  typedef struct packed {
    logic        pixel_out;
    logic [15:0] iterations_done;
    logic        hit_limit;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITER,
    S_SCAN,
    S_CLEAR,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic accept;
    logic run_init;
    logic iter_begin;
    logic set_limited;
    logic cnt_init;
    logic any_clr;
    logic scan_step;
    logic clear_step;
    logic sub_clr;
    logic sub_set;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic lim_reached;
    logic k_end;
    logic k_odd;
    logic pix_last;
    logic any_del;
    logic second;
  } status_t;

  // Step 0 reads the center pixel, steps 1 to 8 read p2 through p9.
  function automatic logic signed [1:0] nbr_dr(input logic [3:0] k);
    logic signed [1:0] d;
    unique case (k)
      4'd1, 4'd2, 4'd8: d = -2'sd1;
      4'd4, 4'd5, 4'd6: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nbr_dc(input logic [3:0] k);
    logic signed [1:0] d;
    unique case (k)
      4'd2, 4'd3, 4'd4: d = 2'sd1;
      4'd6, 4'd7, 4'd8: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/bitu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Binary image thinning controller
// Sequences pixel transactions, iterations, scan and clear passes, and owns
// the handshake and result staging flags.
// ----------------------------------------------------------------------------
module bitu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  output logic               out_valid,
  input  logic               out_stall,
  output bitu_pkg::cmd_t     cmd,
  input  bitu_pkg::status_t  status
);

  bitu_pkg::state_t state, state_next;
  logic pend_v, pend_v_next;
  logic out_v, out_v_next;
  logic out_can;
  logic finish;

  assign out_can   = !out_v || !out_stall;
  assign in_stall  = !((state == bitu_pkg::S_IDLE) && (!pend_v || out_can));
  assign out_valid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bitu_pkg::S_IDLE;
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      state  <= state_next;
      pend_v <= pend_v_next;
      out_v  <= out_v_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    finish     = 1'b0;
    cmd.accept   = in_valid && !in_stall;
    cmd.out_load = pend_v && out_can;
    unique case (state)
      bitu_pkg::S_IDLE: begin
        if (cmd.accept) begin
          if (in_op == bitu_pkg::OP_RUN) begin
            cmd.run_init = 1'b1;
            state_next   = bitu_pkg::S_ITER;
          end else begin
            finish = 1'b1;
          end
        end
      end
      bitu_pkg::S_ITER: begin
        if (status.lim_reached) begin
          cmd.set_limited = 1'b1;
          finish          = 1'b1;
          state_next      = bitu_pkg::S_IDLE;
        end else begin
          cmd.iter_begin = 1'b1;
          cmd.sub_clr    = 1'b1;
          cmd.cnt_init   = 1'b1;
          cmd.any_clr    = 1'b1;
          state_next     = bitu_pkg::S_SCAN;
        end
      end
      bitu_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.k_end && status.pix_last) begin
          cmd.cnt_init  = 1'b1;
          state_next    = bitu_pkg::S_CLEAR;
        end
      end
      bitu_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.k_odd && status.pix_last) begin
          state_next = bitu_pkg::S_DECIDE;
        end
      end
      bitu_pkg::S_DECIDE: begin
        if (!status.any_del) begin
          finish     = 1'b1;
          state_next = bitu_pkg::S_IDLE;
        end else if (!status.second) begin
          cmd.sub_set  = 1'b1;
          cmd.cnt_init = 1'b1;
          cmd.any_clr  = 1'b1;
          state_next   = bitu_pkg::S_SCAN;
        end else begin
          state_next = bitu_pkg::S_ITER;
        end
      end
      default: state_next = bitu_pkg::S_IDLE;
    endcase
    pend_v_next = finish || (pend_v && !cmd.out_load);
    out_v_next  = cmd.out_load || (out_v && out_stall);
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> state == bitu_pkg::S_IDLE)
    else $error("transaction accepted while a run is in progress");

  assert property (@(posedge clk) disable iff (rst)
    pend_v && !out_can |=> pend_v)
    else $error("staged result lost while the output was stalled");

  // The scan step of the last pixel must hand over to the clear pass.
  assert property (@(posedge clk) disable iff (rst)
    state == bitu_pkg::S_SCAN && status.k_end && status.pix_last
      |-> cmd.scan_step ##1 state == bitu_pkg::S_CLEAR)
    else $error("scan pass did not hand over after its last pixel");

  assert property (@(posedge clk) disable iff (rst)
    state == bitu_pkg::S_CLEAR && status.k_odd && status.pix_last
      |=> state == bitu_pkg::S_DECIDE)
    else $error("clear pass did not end after its last pixel");

  assert property (@(posedge clk) disable iff (rst)
    state != bitu_pkg::S_IDLE |-> !pend_v || cmd.out_load || $past(pend_v))
    else $error("result staged during a run");

endmodule

// ===== rtl/core/bitu_dp.sv =====
// ----------------------------------------------------------------------------
// Binary image thinning datapath
// Image and delete mark stores, scan counters, neighbor window, the
// Zhang-Suen test, iteration bookkeeping and the result register.
// ----------------------------------------------------------------------------
module bitu_dp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  bitu_pkg::cmd_t      cmd,
  output bitu_pkg::status_t   status,
  input  bitu_pkg::in_item_t  in_data,
  output bitu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [6:0]  image_width, image_height;
  logic [15:0] max_iterations;
  logic [15:0] count;
  logic        limited;
  logic        second;
  logic        any_del;
  logic        pend_rd;

  logic [RW-1:0] r;
  logic [CW-1:0] c;
  logic [3:0]    k;
  logic [7:0]    nb;
  logic          rv_q;

  logic img_mem  [DEPTH];
  logic mark_mem [DEPTH];
  logic img_q, mk_q;

  logic [CW:0] w_eff, nc;
  logic [RW:0] h_eff, nr;
  logic [31:0] w32, h32;
  logic        nvalid, cur, mark, in_store, pix_last;
  logic [8:0]  win;
  logic [AW-1:0] naddr, caddr, xaddr;
  logic        img_we, img_wdata, img_re;
  logic [AW-1:0] img_waddr, img_raddr;

  // Sizes of the image in use; zero acts as one, oversize acts as the store.
  always_comb begin
    w32 = 32'(image_width);
    h32 = 32'(image_height);
    if (w32 == 32'd0) w_eff = (CW+1)'(1);
    else if (w32 > 32'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(w32);
    if (h32 == 32'd0) h_eff = (RW+1)'(1);
    else if (h32 > 32'(MAX_HEIGHT)) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(h32);
  end

  // A neighbor above row 0 or left of column 0 wraps to all ones and fails
  // the bound check as well.
  always_comb begin
    nr     = (RW+1)'({1'b0, r}) + (RW+1)'(bitu_pkg::nbr_dr(k));
    nc     = (CW+1)'({1'b0, c}) + (CW+1)'(bitu_pkg::nbr_dc(k));
    nvalid = (nr < h_eff) && (nc < w_eff);
    naddr  = AW'(32'(nr[RW-1:0]) * MAX_WIDTH + 32'(nc[CW-1:0]));
    caddr  = AW'(32'(r) * MAX_WIDTH + 32'(c));
    xaddr  = AW'(32'(in_data.row) * MAX_WIDTH + 32'(in_data.col));
    in_store = (32'(in_data.row) < 32'(MAX_HEIGHT)) && (32'(in_data.col) < 32'(MAX_WIDTH));
    pix_last = (c == CW'(w_eff - (CW+1)'(1))) && (r == RW'(h_eff - (RW+1)'(1)));
  end

  assign cur = img_q & rv_q;
  assign win = {nb, cur};

  // Window: win[8] is the center, win[7-j] is ring neighbor j (p2 first).
  always_comb begin
    logic [7:0] n;
    logic [3:0] sum, trans;
    logic       cond;
    n     = win[7:0];
    sum   = '0;
    trans = '0;
    for (int j = 0; j < 8; j++) begin
      sum = sum + 4'(n[7-j]);
      if (!n[7-j] && n[7-((j+1)%8)]) trans = trans + 4'd1;
    end
    if (!second)
      cond = !(n[7] & n[5] & n[3]) && !(n[5] & n[3] & n[1]);
    else
      cond = !(n[7] & n[5] & n[1]) && !(n[7] & n[3] & n[1]);
    mark = win[8] && (sum >= 4'd2) && (sum <= 4'd6) && (trans == 4'd1) && cond;
  end

  always_comb begin
    img_we    = 1'b0;
    img_waddr = caddr;
    img_wdata = 1'b0;
    img_re    = 1'b0;
    img_raddr = naddr;
    if (cmd.accept && in_data.op == bitu_pkg::OP_WRITE && in_store) begin
      img_we    = 1'b1;
      img_waddr = xaddr;
      img_wdata = in_data.pixel_in;
    end else if (cmd.clear_step && k[0] && mk_q) begin
      img_we = 1'b1;
    end
    if (cmd.accept && in_data.op == bitu_pkg::OP_READ && in_store) begin
      img_re    = 1'b1;
      img_raddr = xaddr;
    end else if (cmd.scan_step && k != bitu_pkg::STEP_LAST && nvalid) begin
      img_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (img_we) img_mem[img_waddr] <= img_wdata;
    if (img_re) img_q <= img_mem[img_raddr];
    if (cmd.scan_step && k == bitu_pkg::STEP_LAST) mark_mem[caddr] <= mark;
    if (cmd.clear_step && !k[0]) mk_q <= mark_mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= 7'd64;
      image_height   <= 7'd64;
      max_iterations <= '0;
      count          <= '0;
      limited        <= 1'b0;
      second         <= 1'b0;
      any_del        <= 1'b0;
      pend_rd        <= 1'b0;
      r              <= '0;
      c              <= '0;
      k              <= '0;
      rv_q           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bitu_pkg::CFG_IMAGE_WIDTH:    image_width    <= cfg_wdata[6:0];
          bitu_pkg::CFG_IMAGE_HEIGHT:   image_height   <= cfg_wdata[6:0];
          bitu_pkg::CFG_MAX_ITERATIONS: max_iterations <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.accept) pend_rd <= (in_data.op == bitu_pkg::OP_READ) && in_store;
      if (cmd.run_init) begin
        count   <= '0;
        limited <= 1'b0;
      end
      if (cmd.set_limited) limited <= 1'b1;
      if (cmd.iter_begin && count != bitu_pkg::COUNT_MAX) count <= count + 16'd1;
      if (cmd.sub_clr) second <= 1'b0;
      if (cmd.sub_set) second <= 1'b1;
      if (cmd.any_clr) any_del <= 1'b0;
      else if (cmd.scan_step && k == bitu_pkg::STEP_LAST && mark) any_del <= 1'b1;
      if (cmd.scan_step) rv_q <= nvalid;
      if (cmd.cnt_init) begin
        r <= '0;
        c <= '0;
        k <= '0;
      end else if (cmd.scan_step || cmd.clear_step) begin
        if ((cmd.scan_step && k == bitu_pkg::STEP_LAST) || (cmd.clear_step && k[0])) begin
          k <= '0;
          if (c == CW'(w_eff - (CW+1)'(1))) begin
            c <= '0;
            r <= r + RW'(1);
          end else begin
            c <= c + CW'(1);
          end
        end else begin
          k <= k + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) nb <= {nb[6:0], cur};
    if (cmd.out_load) begin
      out_data.pixel_out       <= pend_rd & img_q;
      out_data.iterations_done <= count;
      out_data.hit_limit       <= limited;
    end
  end

  always_comb begin
    status.lim_reached = (max_iterations != 16'd0) && (count >= max_iterations);
    status.k_end       = (k == bitu_pkg::STEP_LAST);
    status.k_odd       = k[0];
    status.pix_last    = pix_last;
    status.any_del     = any_del;
    status.second      = second;
  end

endmodule

// ===== rtl/core/binary_image_thinning_unit.sv =====
// ----------------------------------------------------------------------------
// Binary image thinning unit
// Zhang-Suen thinning of a binary image held in an on-chip store.
// ----------------------------------------------------------------------------
// Each transaction is one operation: write a pixel, read a pixel, or run the
// thinning. Pixel writes and reads are taken one per cycle while no run is in
// progress and the output is not stalled; a read result is first staged and
// then loaded into the output register. A run thins the image in use by
// repeated iterations of two subpasses: each subpass scans the image pixel by
// pixel, with nine reads through the single read port of the image store
// followed by the test, then clears the marked pixels by reading each mark and
// then writing the pixel. The run stops when a subpass clears nothing or when
// max_iterations iterations have begun (zero means no limit). Every
// transaction gives exactly one result, carrying the pixel read (0 for other
// operations), the iteration count of the last run and whether that run
// stopped at its limit. Pixels that were never written must not be read or
// run over. Configuration is to be written by the user only while no
// transaction is in flight; the block itself does not enforce this.
module binary_image_thinning_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bitu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bitu_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  // Commands flow from the controller to the datapath, status flows back.
  bitu_pkg::cmd_t    cmd;
  bitu_pkg::status_t status;

  bitu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  bitu_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== test/binary_image_thinning_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Binary image thinning unit testbench
// Drives pixel writes, reads and thinning runs through the valid/stall
// channels, predicts every result with an independent thinning model kept in
// a scoreboard class, and checks each result field by field, in order.
// ----------------------------------------------------------------------------
module binary_image_thinning_unit_tb;

  localparam int MAXW = 64;
  localparam int MAXH = 64;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Thinning predictor with its own copy of the image and the settings.
  class thin_scoreboard;
    bit        img[MAXH][MAXW];
    bit        marks[MAXH][MAXW];
    bit [15:0] iter_count;
    bit        limited;
    bit [6:0]  width_reg;
    bit [6:0]  height_reg;
    bit [15:0] limit_reg;
    bitu_pkg::out_item_t pending[$];
    int        errors;

    function new();
      iter_count = 16'd0;
      limited = 1'b0;
      width_reg = 7'd64;
      height_reg = 7'd64;
      limit_reg = 16'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        bitu_pkg::CFG_IMAGE_WIDTH:    width_reg = val[6:0];
        bitu_pkg::CFG_IMAGE_HEIGHT:   height_reg = val[6:0];
        bitu_pkg::CFG_MAX_ITERATIONS: limit_reg = val;
        default: ;
      endcase
    endfunction

    function int used_size(bit [6:0] v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function bit pel(int r, int c, int w, int h);
      if (r < 0 || c < 0 || r >= h || c >= w) return 0;
      return img[r][c];
    endfunction

    // One subpass; returns 1 when some pixel was cleared.
    function bit thin_subpass(int w, int h, bit second);
      bit ring[8];
      int cnt, trans;
      bit any;
      any = 0;
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++) begin
          marks[r][c] = 0;
          if (!img[r][c]) continue;
          ring[0] = pel(r-1, c, w, h);
          ring[1] = pel(r-1, c+1, w, h);
          ring[2] = pel(r, c+1, w, h);
          ring[3] = pel(r+1, c+1, w, h);
          ring[4] = pel(r+1, c, w, h);
          ring[5] = pel(r+1, c-1, w, h);
          ring[6] = pel(r, c-1, w, h);
          ring[7] = pel(r-1, c-1, w, h);
          cnt = 0;
          trans = 0;
          for (int k = 0; k < 8; k++) begin
            cnt += ring[k];
            if (!ring[k] && ring[(k+1)%8]) trans++;
          end
          if (cnt >= 2 && cnt <= 6 && trans == 1) begin
            if (!second)
              marks[r][c] = !(ring[0] & ring[2] & ring[4]) && !(ring[2] & ring[4] & ring[6]);
            else
              marks[r][c] = !(ring[0] & ring[2] & ring[6]) && !(ring[0] & ring[4] & ring[6]);
          end
          if (marks[r][c]) any = 1;
        end
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          if (marks[r][c]) img[r][c] = 0;
      return any;
    endfunction

    function void thin_image();
      int w, h;
      int unsigned n;
      w = used_size(width_reg, MAXW);
      h = used_size(height_reg, MAXH);
      n = 0;
      limited = 0;
      forever begin
        if (limit_reg != 0 && n >= limit_reg) begin
          limited = 1;
          break;
        end
        if (n < bitu_pkg::COUNT_MAX) n++;
        if (!thin_subpass(w, h, 0)) break;
        if (!thin_subpass(w, h, 1)) break;
      end
      iter_count = 16'(n);
    endfunction

    // Notes an accepted input transaction and queues its expected result.
    function void note_input(bitu_pkg::in_item_t t);
      bitu_pkg::out_item_t e;
      e.pixel_out = 0;
      case (t.op)
        bitu_pkg::OP_WRITE: img[t.row][t.col] = t.pixel_in;
        bitu_pkg::OP_READ:  e.pixel_out = img[t.row][t.col];
        bitu_pkg::OP_RUN:   thin_image();
        default: ;
      endcase
      e.iterations_done = iter_count;
      e.hit_limit = limited;
      pending = {pending, e};
    endfunction

    function void check_result(bitu_pkg::out_item_t got);
      bitu_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.pixel_out !== e.pixel_out) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.iterations_done !== e.iterations_done) begin
        $display("%0t: iterations_done expected %0d actual %0d", $time,
                 e.iterations_done, got.iterations_done);
        errors++;
      end
      if (got.hit_limit !== e.hit_limit) begin
        $display("%0t: hit_limit expected %0d actual %0d", $time, e.hit_limit, got.hit_limit);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic                in_valid = 0;
  logic                in_stall;
  bitu_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 0;
  bitu_pkg::out_item_t out_data;
  logic                cfg_we = 0;
  logic [1:0]          cfg_index = bitu_pkg::CFG_IMAGE_WIDTH;
  logic [15:0]         cfg_wdata = '0;

  thin_scoreboard sb = new();

  // Idle rates in percent for sender and receiver; changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;
  bit timed_out = 0;

  // Tracks which pixels have ever been written so random reads stay legal.
  bit written[MAXH][MAXW];

  always #2 clk = ~clk;

  binary_image_thinning_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Result side: sample at the rising edge, update stall at the falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: a long stretch with no transaction on either side ends the run.
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one transaction and waits until it is accepted. Random idle
  // cycles go in front of the offer; valid stays high while stalled and
  // is dropped by the next offer's idle cycles or by drain.
  task automatic send_item(bitu_pkg::in_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(t);
    if (t.op == bitu_pkg::OP_WRITE) written[t.row][t.col] = 1;
    @(negedge clk);
  endtask

  task automatic put_pixel(int r, int c, bit v);
    bitu_pkg::in_item_t t;
    t.op = bitu_pkg::OP_WRITE; t.row = 6'(r); t.col = 6'(c); t.pixel_in = v;
    send_item(t);
  endtask

  task automatic get_pixel(int r, int c);
    bitu_pkg::in_item_t t;
    t.op = bitu_pkg::OP_READ; t.row = 6'(r); t.col = 6'(c);
    t.pixel_in = 1'($urandom_range(1));
    send_item(t);
  endtask

  task automatic start_run();
    bitu_pkg::in_item_t t;
    t.op = bitu_pkg::OP_RUN; t.row = 6'($urandom_range(63)); t.col = 6'($urandom_range(63));
    t.pixel_in = 1'($urandom_range(1));
    send_item(t);
  endtask

  // Waits until every expected result has arrived, plus a short settling gap.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // Fills the image in use with a random pattern of given foreground density,
  // so every pixel the run touches has been written.
  task automatic fill_image(int w, int h, int density);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        put_pixel(r, c, $urandom_range(99) < density);
  endtask

  // One random phase: small image, fill, a mix of traffic, then a run and reads.
  task automatic random_phase(int w, int h, int lim, int n);
    bitu_pkg::in_item_t t;
    int uw, uh;
    uw = (w < 1) ? 1 : ((w > MAXW) ? MAXW : w);
    uh = (h < 1) ? 1 : ((h > MAXH) ? MAXH : h);
    drain();
    write_reg(bitu_pkg::CFG_IMAGE_WIDTH, 16'(w));
    write_reg(bitu_pkg::CFG_IMAGE_HEIGHT, 16'(h));
    write_reg(bitu_pkg::CFG_MAX_ITERATIONS, 16'(lim));
    fill_image(uw, uh, $urandom_range(30, 90));
    for (int i = 0; i < n; i++) begin
      t.row = 6'($urandom_range(uh - 1));
      t.col = 6'($urandom_range(uw - 1));
      t.pixel_in = 1'($urandom_range(1));
      case ($urandom_range(9))
        0, 1, 2: begin t.op = bitu_pkg::OP_WRITE; end
        3, 4, 5, 6: begin t.op = bitu_pkg::OP_READ; end
        7: begin t.op = bitu_pkg::OP_RUN; end
        8: begin
          // Unused operation code; it may carry any address.
          t.op = OP_SPARE; t.row = 6'($urandom_range(63)); t.col = 6'($urandom_range(63));
        end
        default: begin
          // Pixel anywhere in the store, possibly outside the image in use.
          t.op = bitu_pkg::OP_WRITE;
          t.row = 6'($urandom_range(63)); t.col = 6'($urandom_range(63));
        end
      endcase
      if (t.op == bitu_pkg::OP_READ && !written[t.row][t.col]) t.op = bitu_pkg::OP_WRITE;
      send_item(t);
    end
    start_run();
    for (int r = 0; r < uh; r++)
      for (int c = 0; c < uw; c++)
        if ($urandom_range(3) == 0) get_pixel(r, c);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part: a solid 3x4 block on a 5x5 image, extreme addresses,
    // reads, the unused code, a run to convergence and a limited run.
    write_reg(bitu_pkg::CFG_IMAGE_WIDTH, 16'd5);
    write_reg(bitu_pkg::CFG_IMAGE_HEIGHT, 16'd5);
    write_reg(bitu_pkg::CFG_MAX_ITERATIONS, 16'd0);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++)
        put_pixel(r, c, (r >= 1 && r <= 3 && c >= 0 && c <= 3));
    put_pixel(63, 63, 1);
    put_pixel(0, 63, 1);
    get_pixel(63, 63);
    get_pixel(2, 2);
    begin
      bitu_pkg::in_item_t t;
      t.op = OP_SPARE; t.row = 6'h3F; t.col = 6'h3F; t.pixel_in = 1;
      send_item(t);
    end
    start_run();
    get_pixel(2, 1);
    get_pixel(63, 63);
    drain();
    // A limit of one iteration on a fresh thick block.
    write_reg(bitu_pkg::CFG_MAX_ITERATIONS, 16'd1);
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++)
        put_pixel(r, c, 1);
    start_run();
    start_run();
    get_pixel(0, 0);

    // Sender idles seldom, receiver often.
    send_idle_pct = 7;
    recv_idle_pct = 83;
    random_phase(1, 1, 0, 10);
    random_phase(5, 5, 2, 10);
    random_phase(3, 8, 0, 10);

    // Sender idles often, receiver seldom.
    send_idle_pct = 83;
    recv_idle_pct = 7;
    random_phase(8, 3, 0, 10);
    random_phase(6, 6, 1, 10);

    // No idling; a long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    hold_off_cycles = 300;
    for (int i = 0; i < 20; i++) get_pixel($urandom_range(5), $urandom_range(5));
    random_phase(6, 6, 16'hFFFF, 10);
    random_phase(2, 9, 0, 10);

    // Out-of-range size values; the oversize width uses the full row.
    random_phase(0, 0, 0, 10);
    random_phase(127, 1, 0, 10);

    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
